// File: rtl/sfp_pkg.sv
// Package for the sensor frame parser: item structs, parser phase codes,
// replay codes, operation codes, configuration register indexes and reset values.
// No dependencies; imported by sensor_frame_parser and sfp_checker.
`default_nettype none

package sfp_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

  // Register reset values
  localparam logic [7:0] HEADER_BYTE_RST = 8'd239;
  localparam logic [7:0] DEVICE_ID_RST   = 8'd81;
  localparam logic [6:0] MAX_PAYLOAD_RST = 7'd64;

  // Input operation codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Frame parse phases
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_DEV  = 3'd1,
    PH_SYS  = 3'd2,
    PH_MSG  = 3'd3,
    PH_SEQ  = 3'd4,
    PH_LEN  = 3'd5,
    PH_PAY  = 3'd6,
    PH_CHK  = 3'd7
  } phase_e;

  // Payload replay sequencer
  typedef enum logic [1:0] {
    RP_IDLE = 2'd0,
    RP_READ = 2'd1,
    RP_LOAD = 2'd2
  } replay_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic       payload_valid;
    logic [7:0] system_id;
    logic [7:0] message_id;
    logic [7:0] sequence_res;
    logic [6:0] payload_length;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/sensor_frame_parser.sv
// Flow: after a good checksum byte, each payload result takes one payload store
// read and then an output register load, and the load waits while the output
// is stalled. A frame with no payload gives its single result from the output
// register in the cycle after the checksum byte is taken. Input is stalled while
// the payload replays; the store read and the output register load set that pace.
// Reset: control and configuration registers reset at once; no clearing pass.
// Byte-serial frame parser: header/id/length checks, sum-8 checksum, payload
// store in a synchronous memory and replay of the stored payload. Uses sfp_pkg.
`default_nettype none

module sensor_frame_parser
  import sfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_item_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_item_o,
  // configuration writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]           cfg_data_i
);

  localparam int unsigned AW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
  localparam logic [8:0]  DEPTH = 9'(MAX_PAYLOAD_BYTES);

  // Configuration registers
  logic [7:0] header_byte_q, device_id_q;
  logic [6:0] max_payload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_byte_q <= HEADER_BYTE_RST;
      device_id_q   <= DEVICE_ID_RST;
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEADER_BYTE: header_byte_q <= cfg_data_i;
        CFG_DEVICE_ID:   device_id_q   <= cfg_data_i;
        CFG_MAX_PAYLOAD: max_payload_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Parser state
  phase_e     phase_q, phase_d;
  replay_e    rep_q, rep_d;
  logic [7:0] sum_q, sum_d;
  logic [6:0] count_q, count_d;
  logic [6:0] rd_idx_q, rd_idx_d;
  logic [7:0] sys_q, sys_d, msg_q, msg_d, seq_q, seq_d;
  logic [6:0] len_q, len_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  // Payload store: one write port, one registered read port
  logic [7:0]    store_mem [MAX_PAYLOAD_BYTES];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= store_mem[mem_raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      rep_q       <= RP_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      sys_q       <= '0;
      msg_q       <= '0;
      seq_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      rep_q       <= rep_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      sys_q       <= sys_d;
      msg_q       <= msg_d;
      seq_q       <= seq_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Input stalls during replay (no store overlap) and, in the checksum phase,
  // while the output register still holds a result.
  assign in_stall_o  = (rep_q != RP_IDLE) || ((phase_q == PH_CHK) && out_valid_q);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  logic       in_acc, out_free;
  logic [7:0] b, limit, sum_add;
  logic [6:0] count_inc;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign b         = in_item_i.byte_in;
  assign sum_add   = sum_q + b;
  assign count_inc = count_q + 7'd1;
  assign limit     = ({2'b00, max_payload_q} < DEPTH) ? {1'b0, max_payload_q} : DEPTH[7:0];

  // Next state: parser phases, replay sequencer, output register
  always_comb begin
    phase_d     = phase_q;
    rep_d       = rep_q;
    sum_d       = sum_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    sys_d       = sys_q;
    msg_d       = msg_q;
    seq_d       = seq_q;
    len_d       = len_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = AW'(count_q);
    mem_wdata   = b;
    mem_re      = 1'b0;
    mem_raddr   = AW'(rd_idx_q);

    if (in_acc) begin
      if (in_item_i.operation == OP_RESTART) begin
        phase_d = PH_HUNT;
        count_d = '0;
        sum_d   = '0;
      end else begin
        unique case (phase_q)
          PH_HUNT: begin
            if (b == header_byte_q) begin
              sum_d   = b;
              phase_d = PH_DEV;
            end
          end
          PH_DEV: begin
            if (b == device_id_q) begin
              sum_d   = sum_add;
              phase_d = PH_SYS;
            end else begin
              phase_d = PH_HUNT;
              count_d = '0;
              sum_d   = '0;
            end
          end
          PH_SYS: begin
            sys_d   = b;
            sum_d   = sum_add;
            phase_d = PH_MSG;
          end
          PH_MSG: begin
            msg_d   = b;
            sum_d   = sum_add;
            phase_d = PH_SEQ;
          end
          PH_SEQ: begin
            seq_d   = b;
            sum_d   = sum_add;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            if (b > limit) begin
              phase_d = PH_HUNT;
              count_d = '0;
              sum_d   = '0;
            end else begin
              len_d   = b[6:0];
              sum_d   = sum_add;
              count_d = '0;
              phase_d = (b == 8'd0) ? PH_CHK : PH_PAY;
            end
          end
          PH_PAY: begin
            mem_we = ({2'b00, count_q} < DEPTH);
            sum_d  = sum_add;
            if (count_inc >= len_q) begin
              count_d = '0;
              phase_d = PH_CHK;
            end else begin
              count_d = count_inc;
            end
          end
          PH_CHK: begin
            phase_d = PH_HUNT;
            count_d = '0;
            sum_d   = '0;
            if (b == sum_q) begin
              if (len_q == 7'd0) begin
                // empty payload: one marker result
                out_valid_d          = 1'b1;
                out_d.payload_byte   = '0;
                out_d.payload_index  = '0;
                out_d.payload_valid  = 1'b0;
                out_d.system_id      = sys_q;
                out_d.message_id     = msg_q;
                out_d.sequence_res   = seq_q;
                out_d.payload_length = len_q;
                out_d.last           = 1'b1;
              end else begin
                rep_d    = RP_READ;
                rd_idx_d = '0;
              end
            end
          end
          default: ;
        endcase
      end
    end

    // Replay: read one entry, then load it once the output register frees up
    unique case (rep_q)
      RP_IDLE: ;
      RP_READ: begin
        mem_re = 1'b1;
        rep_d  = RP_LOAD;
      end
      RP_LOAD: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.payload_byte   = mem_rdata_q;
          out_d.payload_index  = rd_idx_q[5:0];
          out_d.payload_valid  = 1'b1;
          out_d.system_id      = sys_q;
          out_d.message_id     = msg_q;
          out_d.sequence_res   = seq_q;
          out_d.payload_length = len_q;
          out_d.last           = ((rd_idx_q + 7'd1) == len_q);
          if ((rd_idx_q + 7'd1) == len_q) begin
            rep_d = RP_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + 7'd1;
            rep_d    = RP_READ;
          end
        end
      end
      default: rep_d = RP_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/sfp_checker.sv
// Port-level checks for sensor_frame_parser, attached by the bind below.
// Uses sfp_pkg for the item structs.
`default_nettype none

module sfp_checker
  import sfp_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // only the final item of a run may be an empty-payload marker
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.payload_valid |->
      out_item_o.last && out_item_o.payload_length == 7'd0 &&
      out_item_o.payload_index == 6'd0)
    else $error("malformed empty-payload item");

  // real payload bytes belong to a frame with a nonzero length
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.payload_valid |-> out_item_o.payload_length != 7'd0)
    else $error("payload byte from empty frame");

  // the parser takes no byte while a payload run is still going out
  a_replay_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> in_stall_o)
    else $error("input taken during replay");

endmodule

bind sensor_frame_parser sfp_checker u_sfp_checker (.*);

`default_nettype wire
